// ----- rtl/jet_pkg.sv -----
// jet_pkg: shared widths, codes and helpers for the Julia escape-time block.
// No dependencies; every other file of the block refers to it by scoped names.
package jet_pkg;

  // Field widths
  localparam int PIX_W     = 11;
  localparam int IDX_W     = 7;
  localparam int DATA_W    = 32;
  localparam int FRAME_W   = 12;
  localparam int STEP_W    = 31;
  localparam int FRAC_BITS = 27;
  localparam int PADDR_W   = 5;

  // Largest reportable escape index
  localparam logic [IDX_W-1:0] IDX_MAX = 7'd127;

  // Escape threshold: 4.0 in Q10.54
  localparam logic [63:0] ESC_LIMIT = 64'h0100_0000_0000_0000;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SRE,
    S_SIM,
    S_XX,
    S_YY,
    S_XY,
    S_CHK,
    S_OUT
  } state_e;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_CENTER_RE,
    REG_CENTER_IM,
    REG_STEP_RE,
    REG_STEP_IM,
    REG_SEED_RE,
    REG_SEED_IM,
    REG_FRAME_W,
    REG_FRAME_H
  } cfg_reg_e;

  // Saturate a signed 65-bit value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic [33:0] top;
    top = v[64:31];
    if ((&top) || !(|top)) begin
      return v[31:0];
    end else if (v[64]) begin
      return {1'b1, {31{1'b0}}};
    end else begin
      return {1'b0, {31{1'b1}}};
    end
  endfunction

endpackage

// ----- rtl/jet_if.sv -----
// jet_if: valid/ready channel interfaces for pixel items and result items.
// Depends on jet_pkg for field widths.
interface jet_pix_if;
  logic                       valid;
  logic                       ready;
  logic [jet_pkg::PIX_W-1:0]  pix_x;
  logic [jet_pkg::PIX_W-1:0]  pix_y;

  modport source (output valid, pix_x, pix_y, input ready);
  modport sink   (input valid, pix_x, pix_y, output ready);
endinterface

interface jet_res_if;
  logic                       valid;
  logic                       ready;
  logic [jet_pkg::PIX_W-1:0]  out_x;
  logic [jet_pkg::PIX_W-1:0]  out_y;
  logic                       escaped;
  logic [jet_pkg::IDX_W-1:0]  escape_index;

  modport source (output valid, out_x, out_y, escaped, escape_index, input ready);
  modport sink   (input valid, out_x, out_y, escaped, escape_index, output ready);
endinterface

// ----- rtl/julia_escape_time.sv -----
// julia_escape_time: Julia-set escape-time kernel, one pixel item at a time.
// Depends on jet_pkg and the channel interfaces in jet_if.sv.
//
//   channel   dir  handshake      payload
//   pix_i     in   valid/ready    pix_x, pix_y
//   res_o     out  valid/ready    out_x, out_y, escaped, escape_index
//   apb       in   psel/penable   paddr, pwdata, prdata (word per register)
//
// One 32x32 signed multiplier with a registered product is shared by all steps.
// A result is valid once its item has run the sequencer: S_SRE and S_SIM form
// the start point, each pass (1..MAX_ITER of them) takes three multiplies and
// a check, and S_OUT loads the output register. pix_i is ready only in idle,
// so the next item is accepted only once the last has left the sequencer. A
// finished result waits in the output register while the next item is accepted,
// and the sequencer holds in its last state if that register is still full.
// rst_ni resets control state, output valid and the configuration registers.
module julia_escape_time #(
  parameter int MAX_ITER = 127,
  parameter int MAX_DIM  = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  jet_pix_if.sink                      pix_i,
  jet_res_if.source                    res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jet_pkg::PADDR_W-1:0]  paddr,
  input  logic [jet_pkg::DATA_W-1:0]   pwdata,
  output logic [jet_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int ITER_W = (MAX_ITER > 1) ? $clog2(MAX_ITER) : 1;

  // Configuration registers
  logic signed [31:0]                center_re_q, center_im_q, seed_re_q, seed_im_q;
  logic [jet_pkg::STEP_W-1:0]        step_re_q, step_im_q;
  logic [jet_pkg::FRAME_W-1:0]       frame_w_q, frame_h_q;

  // Sequencer and datapath
  jet_pkg::state_e                   state_q, state_d;
  logic [ITER_W-1:0]                 iter_q;
  logic [jet_pkg::PIX_W-1:0]         pix_x_q, pix_y_q;
  logic signed [31:0]                x_q, y_q;
  logic signed [63:0]                prod_q, xx_q, yy_q;
  logic signed [63:0]                prod_d;
  logic signed [31:0]                mul_a, mul_b;
  logic                              esc_q;

  // Output register
  logic                              res_valid_q;
  logic [jet_pkg::PIX_W-1:0]         out_x_q, out_y_q;
  logic                              out_esc_q;
  logic [jet_pkg::IDX_W-1:0]         out_idx_q;

  // Control
  logic                              accept;
  logic                              out_load;
  logic                              last_pass;
  logic                              escape;
  logic [63:0]                       mag;
  logic [31:0]                       dim_w, dim_h;
  logic signed [31:0]                dx, dy;
  logic signed [64:0]                diff_sh, xy_sh;
  logic [31:0]                       iter_ext;
  logic [jet_pkg::IDX_W-1:0]         idx_sat;
  logic                              cfg_wr;

  // Register writes: APB access phase with pwrite
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_re_q <= '0;
      center_im_q <= '0;
      step_re_q   <= 31'd524288;
      step_im_q   <= 31'd524288;
      seed_re_q   <= '0;
      seed_im_q   <= '0;
      frame_w_q   <= 12'd512;
      frame_h_q   <= 12'd512;
    end else if (cfg_wr) begin
      unique case (jet_pkg::cfg_reg_e'(paddr[4:2]))
        jet_pkg::REG_CENTER_RE: center_re_q <= pwdata;
        jet_pkg::REG_CENTER_IM: center_im_q <= pwdata;
        jet_pkg::REG_STEP_RE:   step_re_q   <= pwdata[jet_pkg::STEP_W-1:0];
        jet_pkg::REG_STEP_IM:   step_im_q   <= pwdata[jet_pkg::STEP_W-1:0];
        jet_pkg::REG_SEED_RE:   seed_re_q   <= pwdata;
        jet_pkg::REG_SEED_IM:   seed_im_q   <= pwdata;
        jet_pkg::REG_FRAME_W:   frame_w_q   <= pwdata[jet_pkg::FRAME_W-1:0];
        jet_pkg::REG_FRAME_H:   frame_h_q   <= pwdata[jet_pkg::FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    unique case (jet_pkg::cfg_reg_e'(paddr[4:2]))
      jet_pkg::REG_CENTER_RE: prdata = center_re_q;
      jet_pkg::REG_CENTER_IM: prdata = center_im_q;
      jet_pkg::REG_STEP_RE:   prdata = {1'b0, step_re_q};
      jet_pkg::REG_STEP_IM:   prdata = {1'b0, step_im_q};
      jet_pkg::REG_SEED_RE:   prdata = seed_re_q;
      jet_pkg::REG_SEED_IM:   prdata = seed_im_q;
      jet_pkg::REG_FRAME_W:   prdata = {20'b0, frame_w_q};
      jet_pkg::REG_FRAME_H:   prdata = {20'b0, frame_h_q};
      default:                prdata = '0;
    endcase
  end

  // Clamp frame sizes to 1..MAX_DIM and form 2*pix - frame
  always_comb begin
    if (frame_w_q == '0) begin
      dim_w = 32'd1;
    end else if (32'(frame_w_q) > 32'(MAX_DIM)) begin
      dim_w = 32'(MAX_DIM);
    end else begin
      dim_w = 32'(frame_w_q);
    end
    if (frame_h_q == '0) begin
      dim_h = 32'd1;
    end else if (32'(frame_h_q) > 32'(MAX_DIM)) begin
      dim_h = 32'(MAX_DIM);
    end else begin
      dim_h = 32'(frame_h_q);
    end
    dx = signed'({20'b0, pix_x_q, 1'b0}) - signed'(dim_w);
    dy = signed'({20'b0, pix_y_q, 1'b0}) - signed'(dim_h);
  end

  // Pick multiplier operands per step
  always_comb begin
    case (state_q)
      jet_pkg::S_SRE: begin
        mul_a = dx;
        mul_b = signed'({1'b0, step_re_q});
      end
      jet_pkg::S_SIM: begin
        mul_a = dy;
        mul_b = signed'({1'b0, step_im_q});
      end
      jet_pkg::S_YY: begin
        mul_a = y_q;
        mul_b = y_q;
      end
      jet_pkg::S_XY: begin
        mul_a = x_q;
        mul_b = y_q;
      end
      default: begin
        mul_a = x_q;
        mul_b = x_q;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Escape test and update terms, floor by arithmetic shift
  assign mag      = $unsigned(xx_q) + $unsigned(yy_q);
  assign escape   = mag > jet_pkg::ESC_LIMIT;
  assign diff_sh  = ((65'(xx_q) - 65'(yy_q)) >>> jet_pkg::FRAC_BITS) + 65'(seed_re_q);
  assign xy_sh    = (65'(prod_q) >>> (jet_pkg::FRAC_BITS - 1)) + 65'(seed_im_q);
  assign last_pass = (iter_q == ITER_W'(MAX_ITER - 1));

  // Report index, capped at the field's range
  assign iter_ext = 32'(iter_q);
  assign idx_sat  = (iter_ext > 32'(jet_pkg::IDX_MAX)) ? jet_pkg::IDX_MAX
                                                       : iter_ext[jet_pkg::IDX_W-1:0];

  // Next state and handshake
  always_comb begin
    state_d     = state_q;
    pix_i.ready = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      jet_pkg::S_IDLE: begin
        pix_i.ready = 1'b1;
        if (pix_i.valid) state_d = jet_pkg::S_SRE;
      end
      jet_pkg::S_SRE: state_d = jet_pkg::S_SIM;
      jet_pkg::S_SIM: state_d = jet_pkg::S_XX;
      jet_pkg::S_XX:  state_d = jet_pkg::S_YY;
      jet_pkg::S_YY:  state_d = jet_pkg::S_XY;
      jet_pkg::S_XY:  state_d = jet_pkg::S_CHK;
      jet_pkg::S_CHK: begin
        if (escape || last_pass) begin
          state_d = jet_pkg::S_OUT;
        end else begin
          state_d = jet_pkg::S_XX;
        end
      end
      jet_pkg::S_OUT: begin
        if (!res_valid_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = jet_pkg::S_IDLE;
        end
      end
      default: state_d = jet_pkg::S_IDLE;
    endcase
  end

  assign accept = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jet_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath: latch the item, run the shared multiplier, update z
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (accept) begin
      pix_x_q <= pix_i.pix_x;
      pix_y_q <= pix_i.pix_y;
      iter_q  <= '0;
    end
    case (state_q)
      jet_pkg::S_SIM: x_q  <= jet_pkg::sat32(65'(prod_q) + 65'(center_re_q));
      jet_pkg::S_XX: begin
        // load the imaginary start only on the first pass
        if (iter_q == '0) y_q <= jet_pkg::sat32(65'(prod_q) + 65'(center_im_q));
      end
      jet_pkg::S_YY:  xx_q <= prod_q;
      jet_pkg::S_XY:  yy_q <= prod_q;
      jet_pkg::S_CHK: begin
        esc_q <= escape;
        if (!escape) begin
          x_q <= jet_pkg::sat32(diff_sh);
          y_q <= jet_pkg::sat32(xy_sh);
          if (!last_pass) iter_q <= iter_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register: load the finished item, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q   <= pix_x_q;
      out_y_q   <= pix_y_q;
      out_esc_q <= esc_q;
      out_idx_q <= esc_q ? idx_sat : '0;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.out_x        = out_x_q;
  assign res_o.out_y        = out_y_q;
  assign res_o.escaped      = out_esc_q;
  assign res_o.escape_index = out_idx_q;

  // An accepted item starts the start-point multiply next cycle
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == jet_pkg::S_SRE))
    else $error("accepted item did not start the sequencer");

  // A never-escaped result carries a zero index
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.escaped) |-> (res_o.escape_index == '0))
    else $error("non-escaped result has nonzero index");

  // New results appear only out of the final sequencer state
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(state_q == jet_pkg::S_OUT))
    else $error("result valid rose outside the output step");

  // Pass counter stays below the pass limit while checking
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jet_pkg::S_CHK) |-> (32'(iter_q) < 32'(MAX_ITER)))
    else $error("pass counter exceeded limit");

  // A full output register that is not taken keeps the sequencer waiting
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jet_pkg::S_OUT && res_valid_q && !res_o.ready)
      |=> (state_q == jet_pkg::S_OUT))
    else $error("result overwritten while output stalled");

endmodule

// ----- tb/julia_escape_time_tb.sv -----
// julia_escape_time_tb: self-checking bench for the Julia escape-time kernel.
// Depends on jet_pkg, the channel interfaces in jet_if.sv and julia_escape_time.
// A directed table runs first, then randomized views under three idling mixes.
module julia_escape_time_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PASS_LIMIT   = 127;    // passes per pixel in the block
  localparam int DIM_LIMIT    = 2048;   // largest usable frame size
  localparam int QUIET_LIMIT  = 4000;   // cycles with no item moving
  localparam int DRAIN_CYCLES = 520;    // one full 127-pass item plus margin
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 160;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam logic [64:0] ESCAPE_BOUND = 65'd1 << 56;  // 4.0 in Q10.54

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    jet_pkg::cfg_reg_e          regsel;
    logic [31:0]                wdata;
    logic [jet_pkg::PIX_W-1:0]  px;
    logic [jet_pkg::PIX_W-1:0]  py;
    logic                       known;
    logic                       k_esc;
    logic [jet_pkg::IDX_W-1:0]  k_idx;
  } dir_row_t;

  typedef struct {
    logic [jet_pkg::PIX_W-1:0] x;
    logic [jet_pkg::PIX_W-1:0] y;
    logic                      esc;
    logic [jet_pkg::IDX_W-1:0] idx;
  } pixel_result_t;

  // Directed rows: known results are typed in, the rest go through the predictor
  localparam int DIR_ROWS = 37;
  localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
    // reset view: center pixel, corners, fixed point at 1.0, exact |z|^2 = 4
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd256, 11'd256, 1'b1, 1'b0, 7'd0},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd0, 11'd0, 1'b1, 1'b1, 7'd0},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd2047, 11'd2047, 1'b1, 1'b1, 7'd0},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd384, 11'd256, 1'b1, 1'b0, 7'd0},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd512, 11'd256, 1'b1, 1'b1, 7'd1},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd0, 11'd2047, 1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd2047, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd255, 11'd257, 1'b0, 1'b0, 7'd0},
    // classic seed near -0.8 + 0.156i
    '{ROW_WRITE, jet_pkg::REG_SEED_RE, 32'hF999_999A, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_WRITE, jet_pkg::REG_SEED_IM, 32'h013F_7CED, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd300, 11'd260, 1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd180, 11'd330, 1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd400, 11'd100, 1'b0, 1'b0, 7'd0},
    // frame sizes out of range: zero width, oversize height
    '{ROW_WRITE, jet_pkg::REG_FRAME_W, 32'h0, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_WRITE, jet_pkg::REG_FRAME_H, 32'hFFF, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd1, 11'd1024, 1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd2047, 11'd2047, 1'b0, 1'b0, 7'd0},
    // start point clipped at both ends of the range
    '{ROW_WRITE, jet_pkg::REG_CENTER_RE, 32'h7FFF_FFFF, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_WRITE, jet_pkg::REG_CENTER_IM, 32'h8000_0000, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_WRITE, jet_pkg::REG_STEP_RE, 32'hFFFF_FFFF, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_WRITE, jet_pkg::REG_STEP_IM, 32'h7FFF_FFFF, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd2047, 11'd0, 1'b1, 1'b1, 7'd0},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd0, 11'd2047, 1'b0, 1'b0, 7'd0},
    // zero start, extreme seed: first update lands on the seed
    '{ROW_WRITE, jet_pkg::REG_CENTER_RE, 32'h0, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_WRITE, jet_pkg::REG_CENTER_IM, 32'h0, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_WRITE, jet_pkg::REG_STEP_RE, 32'h0, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_WRITE, jet_pkg::REG_STEP_IM, 32'h0, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_WRITE, jet_pkg::REG_SEED_RE, 32'h7FFF_FFFF, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_WRITE, jet_pkg::REG_SEED_IM, 32'h8000_0000, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd5, 11'd7, 1'b1, 1'b1, 7'd1},
    // all zero: never escapes
    '{ROW_WRITE, jet_pkg::REG_SEED_RE, 32'h0, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_WRITE, jet_pkg::REG_SEED_IM, 32'h0, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd2047, 11'd2047, 1'b1, 1'b0, 7'd0},
    // update overflows and clips
    '{ROW_WRITE, jet_pkg::REG_CENTER_RE, 32'h0F33_3333, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_WRITE, jet_pkg::REG_SEED_RE, 32'h7FFF_FFFF, 11'd0, 11'd0, 1'b0, 1'b0, 7'd0},
    '{ROW_PIXEL, jet_pkg::REG_CENTER_RE, 32'h0, 11'd1024, 11'd1024, 1'b0, 1'b0, 7'd0}
  };

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [jet_pkg::PADDR_W-1:0] paddr;
  logic [jet_pkg::DATA_W-1:0]  pwdata;
  logic [jet_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  jet_pix_if pix_if ();
  jet_res_if res_if ();

  julia_escape_time dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the view registers
  logic signed [31:0] ctr_x, ctr_y, seed_x, seed_y;
  logic [30:0]        step_x, step_y;
  logic [11:0]        view_w, view_h;

  pixel_result_t pending[$];
  int errors     = 0;
  int n_items    = 0;
  int n_escaped  = 0;
  int n_bounded  = 0;
  int n_settings = 1;
  int quiet      = 0;
  int src_idle   = 9;
  int sink_idle  = 49;

  always #4 clk_i = ~clk_i;

  // Clip to the signed 32-bit range
  function automatic longint clip32(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // Map one pixel index onto its axis: center + (2*pix - frame) * step
  function automatic longint start_point(input logic [jet_pkg::PIX_W-1:0] pix,
                                         input logic [11:0] frame,
                                         input logic [30:0] stp,
                                         input logic signed [31:0] ctr);
    longint dim;
    dim = longint'(frame);
    if (dim < 1) dim = 1;
    else if (dim > DIM_LIMIT) dim = DIM_LIMIT;
    return clip32((2 * longint'(pix) - dim) * longint'(stp) + longint'(ctr));
  endfunction

  // Iterate z = z^2 + seed and report the first pass with |z|^2 > 4
  function automatic pixel_result_t julia_escape(input logic [jet_pkg::PIX_W-1:0] px,
                                                 input logic [jet_pkg::PIX_W-1:0] py);
    pixel_result_t r;
    longint zr, zi, rr, ii, ri;
    logic [64:0] mag;
    int n;
    r.x   = px;
    r.y   = py;
    r.esc = 1'b0;
    r.idx = '0;
    zr = start_point(px, view_w, step_x, ctr_x);
    zi = start_point(py, view_h, step_y, ctr_y);
    for (n = 0; n < PASS_LIMIT; n++) begin
      rr  = zr * zr;
      ii  = zi * zi;
      ri  = zr * zi;
      mag = {1'b0, rr} + {1'b0, ii};
      if (mag > ESCAPE_BOUND) begin
        r.esc = 1'b1;
        r.idx = n[jet_pkg::IDX_W-1:0];
        break;
      end
      // arithmetic shifts round toward minus infinity
      zr = clip32(((rr - ii) >>> jet_pkg::FRAC_BITS) + longint'(seed_x));
      zi = clip32((ri >>> (jet_pkg::FRAC_BITS - 1)) + longint'(seed_y));
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Offer one pixel item, record its expected result once accepted
  task automatic send_pixel(input logic [jet_pkg::PIX_W-1:0] px,
                            input logic [jet_pkg::PIX_W-1:0] py,
                            input bit known, input bit k_esc,
                            input logic [jet_pkg::IDX_W-1:0] k_idx);
    pixel_result_t r;
    while ($urandom_range(0, 99) < src_idle) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.pix_x <= px;
    pix_if.pix_y <= py;
    do @(posedge clk_i); while (!pix_if.ready);
    if (known) begin
      r.x   = px;
      r.y   = py;
      r.esc = k_esc;
      r.idx = k_idx;
    end else begin
      r = julia_escape(px, py);
    end
    pending.push_back(r);
    n_items++;
    @(negedge clk_i);
  endtask

  // Hold the pixel channel until every expected result is back
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending.size() != 0);
  endtask

  // APB write: setup cycle, access cycle, then a bus-idle cycle
  task automatic write_reg(input jet_pkg::cfg_reg_e r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (r)
      jet_pkg::REG_CENTER_RE: ctr_x  = v;
      jet_pkg::REG_CENTER_IM: ctr_y  = v;
      jet_pkg::REG_STEP_RE:   step_x = v[30:0];
      jet_pkg::REG_STEP_IM:   step_y = v[30:0];
      jet_pkg::REG_SEED_RE:   seed_x = v;
      jet_pkg::REG_SEED_IM:   seed_y = v;
      jet_pkg::REG_FRAME_W:   view_w = v[11:0];
      jet_pkg::REG_FRAME_H:   view_h = v[11:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Pick a new view: a typical Julia window, raw random values, or extremes
  task automatic program_view(input int kind);
    logic [31:0] v [0:7];
    logic [31:0] span;
    int fw, fh, pick, k;
    case (kind)
      0: begin
        fw   = $urandom_range(16, 256);
        fh   = $urandom_range(16, 256);
        span = $urandom_range(32'h0C00_0000, 32'h1000_0000);
        v[jet_pkg::REG_CENTER_RE] = $urandom_range(0, 1 << 26) - (1 << 25);
        v[jet_pkg::REG_CENTER_IM] = $urandom_range(0, 1 << 26) - (1 << 25);
        v[jet_pkg::REG_STEP_RE]   = span / fw;
        v[jet_pkg::REG_STEP_IM]   = span / fh;
        v[jet_pkg::REG_SEED_RE]   = $urandom_range(0, 3 << 26) - (1 << 27);
        v[jet_pkg::REG_SEED_IM]   = $urandom_range(0, 1 << 28) - (1 << 27);
        v[jet_pkg::REG_FRAME_W]   = fw;
        v[jet_pkg::REG_FRAME_H]   = fh;
      end
      1: begin
        for (k = 0; k < 8; k++) v[k] = $urandom();
      end
      default: begin
        for (k = 0; k < 8; k++) begin
          pick = $urandom_range(0, 3);
          if (k == jet_pkg::REG_FRAME_W || k == jet_pkg::REG_FRAME_H) begin
            case (pick)
              0: v[k] = 32'd0;
              1: v[k] = 32'd1;
              2: v[k] = DIM_LIMIT;
              default: v[k] = 32'hFFF;
            endcase
          end else begin
            case (pick)
              0: v[k] = 32'h0000_0000;
              1: v[k] = 32'h8000_0000;
              2: v[k] = 32'h7FFF_FFFF;
              default: v[k] = $urandom();
            endcase
          end
        end
      end
    endcase
    for (k = 0; k < 8; k++) write_reg(jet_pkg::cfg_reg_e'(k), v[k]);
  endtask

  // Randomize result backpressure
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= sink_idle);
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    pixel_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending.size() == 0) begin
        $error("result for pixel (%0d,%0d) with nothing pending",
               res_if.out_x, res_if.out_y);
        errors++;
      end else begin
        want = pending.pop_front();
        check_field("out_x", want.x, res_if.out_x);
        check_field("out_y", want.y, res_if.out_y);
        check_field("escaped", want.esc, res_if.escaped);
        check_field("escape_index", want.idx, res_if.escape_index);
        if (res_if.escaped) n_escaped++;
        else n_bounded++;
      end
    end
  end

  // Stop if no item moves on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("No item moved for %0d cycles, %0d results pending", quiet, pending.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int ph, k, kind;
    logic [jet_pkg::PIX_W-1:0] px, py;

    rst_ni        = 1'b0;
    pix_if.valid  = 1'b0;
    pix_if.pix_x  = '0;
    pix_if.pix_y  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    ctr_x  = '0;
    ctr_y  = '0;
    step_x = 31'd524288;
    step_y = 31'd524288;
    seed_x = '0;
    seed_y = '0;
    view_w = 12'd512;
    view_h = 12'd512;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Walk the directed table
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(DIRECTED[i].regsel, DIRECTED[i].wdata);
      end else begin
        send_pixel(DIRECTED[i].px, DIRECTED[i].py, DIRECTED[i].known,
                   DIRECTED[i].k_esc, DIRECTED[i].k_idx);
      end
    end

    // Random views; idling mix changes every four phases
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph / 4)
        0: begin src_idle = 9;  sink_idle = 49; end
        1: begin src_idle = 49; sink_idle = 9;  end
        default: begin src_idle = 0; sink_idle = 0; end
      endcase
      kind = ph % 3;
      wait_idle();
      program_view(kind);
      n_settings++;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // now and then let the block run completely dry
        if ($urandom_range(0, 59) == 0) wait_idle();
        if (kind == 0 && $urandom_range(0, 4) != 0) begin
          px = $urandom_range(0, view_w - 1);
          py = $urandom_range(0, view_h - 1);
        end else begin
          px = $urandom_range(0, 2047);
          py = $urandom_range(0, 2047);
        end
        send_pixel(px, py, 1'b0, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d pixel items (%0d escaped, %0d bounded) over %0d register settings,",
             n_items, n_escaped, n_bounded, n_settings);
    $display("with directed corner views and three sender/receiver idling mixes.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
